// ===== hw/rtl/acrd_pkg.sv =====
package acrd_pkg;

    // field widths of the stream
    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 32;
    localparam int BITS_W   = 6;

    // bit depth register limits and reset value
    localparam logic [BITS_W-1:0] SAMPLE_BITS_RESET = 6'd16;
    localparam logic [BITS_W-1:0] SAMPLE_BITS_MIN   = 6'd2;
    localparam logic [BITS_W-1:0] SAMPLE_BITS_MAX   = 6'd32;

    // one clip region event
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [POS_W-1:0]  start_idx;
        logic [POS_W-1:0]  end_idx;
        logic              low;
    } t_event;

endpackage

// ===== hw/rtl/audio_clip_region_detector_top.sv =====
// an accepted word passes the input word register and then the output word register before its event shows
// throughput: one word per cycle unless output stalls; per-channel state is read and
// written back in the same cycle, so consecutive words of one channel need no spacing
// reset (i_rst_n low, synchronous): positions and region flags of all channels clear,
// bit depth returns to 16, both word registers empty
module audio_clip_region_detector_top #(
    parameter int CHANNELS  = 8,
    parameter int MERGE_GAP = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [acrd_pkg::BITS_W-1:0]       i_cfg_wr_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [acrd_pkg::CHAN_W-1:0]       i_channel,
    input  logic signed [acrd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_last_in_channel,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [acrd_pkg::CHAN_W-1:0]       o_event_channel,
    output logic [acrd_pkg::POS_W-1:0]        o_start_index,
    output logic [acrd_pkg::POS_W-1:0]        o_end_index,
    output logic                              o_is_low
);

    localparam int ADDR_CH = 1 << acrd_pkg::CHAN_W;
    localparam int DEPTH   = (CHANNELS < ADDR_CH) ? CHANNELS : ADDR_CH;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CR_W    = $clog2(MERGE_GAP + 1);
    localparam int POS_W   = acrd_pkg::POS_W;

    // configuration register
    logic [acrd_pkg::BITS_W-1:0] r_sample_bits;

    // input word register
    logic                                  r_in_valid;
    logic [acrd_pkg::CHAN_W-1:0]           r_channel;
    logic signed [acrd_pkg::SAMPLE_W-1:0]  r_sample;
    logic                                  r_last;

    // per-channel state
    logic [POS_W-1:0] r_position   [DEPTH];
    logic             r_in_region  [DEPTH];
    logic [CR_W-1:0]  r_clean_run  [DEPTH];
    logic [POS_W-1:0] r_region_start [DEPTH];
    logic [POS_W-1:0] r_region_end [DEPTH];
    logic             r_region_low [DEPTH];

    // output word register
    logic             r_out_valid;
    acrd_pkg::t_event r_event;

    logic                        out_free;
    logic                        proc;
    logic                        chan_ok;
    logic [IDX_W-1:0]            idx;
    logic [acrd_pkg::BITS_W-1:0] bits_eff;
    logic [4:0]                  shamt;
    logic [32:0]                 half;
    logic signed [32:0]          hi_thr;
    logic signed [32:0]          lo_thr;
    logic signed [32:0]          s_ext;
    logic                        clip;
    logic                        lo_eq;
    logic [POS_W-1:0]            pos_cur;
    logic [POS_W-1:0]            pos_inc;
    logic [CR_W-1:0]             cr_inc;
    logic                        emit;
    logic                        n_in_region;
    logic [CR_W-1:0]             n_clean_run;
    logic [POS_W-1:0]            n_region_start;
    logic [POS_W-1:0]            n_region_end;
    logic                        n_region_low;
    logic                        n_in_valid;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign n_in_valid = (i_in_valid && !o_in_stall) ? 1'b1 : (proc ? 1'b0 : r_in_valid);

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits <= acrd_pkg::SAMPLE_BITS_RESET;
        end else if (i_cfg_wr_en) begin
            r_sample_bits <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_channel <= i_channel;
            r_sample  <= i_sample;
            r_last    <= i_last_in_channel;
        end
    end

    // clip thresholds for the clamped bit depth
    always_comb begin
        if (r_sample_bits < acrd_pkg::SAMPLE_BITS_MIN) begin
            bits_eff = acrd_pkg::SAMPLE_BITS_MIN;
        end else if (r_sample_bits > acrd_pkg::SAMPLE_BITS_MAX) begin
            bits_eff = acrd_pkg::SAMPLE_BITS_MAX;
        end else begin
            bits_eff = r_sample_bits;
        end
        shamt  = 5'(bits_eff - 6'd1);
        half   = 33'd1 << shamt;
        hi_thr = $signed(half - 33'd1);
        lo_thr = -$signed(half);
        s_ext  = {r_sample[acrd_pkg::SAMPLE_W-1], r_sample};
        clip   = (s_ext >= hi_thr) || (s_ext <= lo_thr);
        lo_eq  = (s_ext == lo_thr);
    end

    // channel lookup
    assign chan_ok = (32'(r_channel) < CHANNELS);
    assign idx     = IDX_W'(r_channel);
    assign pos_cur = r_position[idx];
    assign pos_inc = pos_cur + 32'd1;
    assign cr_inc  = r_clean_run[idx] + CR_W'(1);

    // region tracking for the current channel
    always_comb begin
        n_in_region    = r_in_region[idx];
        n_clean_run    = r_clean_run[idx];
        n_region_start = r_region_start[idx];
        n_region_end   = r_region_end[idx];
        n_region_low   = r_region_low[idx];
        emit           = 1'b0;
        if (!r_in_region[idx]) begin
            if (clip && !r_last) begin
                n_in_region    = 1'b1;
                n_region_start = pos_cur;
                n_region_end   = pos_inc;
                n_region_low   = lo_eq;
                n_clean_run    = '0;
            end
        end else begin
            if (clip) begin
                n_region_end = pos_inc;
                n_clean_run  = '0;
            end else begin
                n_clean_run = cr_inc;
                if (cr_inc >= CR_W'(MERGE_GAP)) begin
                    emit = 1'b1;
                end
            end
            if (r_last) begin
                emit = 1'b1;
            end
        end
        if (emit) begin
            n_in_region = 1'b0;
            n_clean_run = '0;
        end
        // end of channel starts the channel over
        if (r_last) begin
            n_in_region = 1'b0;
            n_clean_run = '0;
        end
        emit = emit && chan_ok;
    end

    // channel control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_position[i]  <= '0;
                r_in_region[i] <= 1'b0;
                r_clean_run[i] <= '0;
            end
        end else if (proc && chan_ok) begin
            r_position[idx]  <= r_last ? '0 : pos_inc;
            r_in_region[idx] <= n_in_region;
            r_clean_run[idx] <= n_clean_run;
        end
    end

    // region bounds, only read while the region is open
    always_ff @(posedge i_clk) begin
        if (proc && chan_ok) begin
            r_region_start[idx] <= n_region_start;
            r_region_end[idx]   <= n_region_end;
            r_region_low[idx]   <= n_region_low;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_event.chan      <= r_channel;
            r_event.start_idx <= n_region_start;
            r_event.end_idx   <= n_region_end;
            r_event.low       <= n_region_low;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_channel = r_event.chan;
    assign o_start_index   = r_event.start_idx;
    assign o_end_index     = r_event.end_idx;
    assign o_is_low        = r_event.low;

`ifndef ASSERT_OFF
    // a closed region never carries a partial clean count
    a_clean_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && chan_ok && !r_in_region[idx]) |-> (r_clean_run[idx] == '0))
        else $error("clean run nonzero outside a region");

    // end of channel restarts the position count
    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && chan_ok && r_last) |=> (r_position[$past(idx)] == '0))
        else $error("position not cleared at end of channel");

    // an empty input register never stalls the upstream side
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall with empty input register");

    // an output word appears only from a processed event
    a_out_from_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc && emit))
        else $error("output word without event");
`endif

endmodule
